FILE: src/ehdc_pkg.sv
// Shared types and constants for the smoothed level controller with hysteresis and dwell.
package ehdc_pkg;

  // Command field of an input item
  localparam int CMD_WIDTH = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_UPDATE = 2'd0,
    CMD_FORCE  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 64;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ALPHA      = 3'd0,
    REG_HIGH_MARK  = 3'd1,
    REG_LOW_MARK   = 3'd2,
    REG_MIN_DWELL  = 3'd3,
    REG_SMOOTHING  = 3'd4,
    REG_HYSTERESIS = 3'd5
  } reg_index_t;

  // Smoothing weight, fixed point with 16 fraction bits; one is 1 << 16
  localparam int ALPHA_FRAC  = 16;
  localparam int ALPHA_WIDTH = ALPHA_FRAC + 1;
  localparam logic [ALPHA_WIDTH-1:0] ALPHA_ONE = 17'h1_0000;

  // Per-item control handed from the input stage to the core
  typedef struct packed {
    cmd_t cmd;
    logic forced_level;
    logic smoothing_on;
    logic hysteresis_on;
  } ctrl_t;

endpackage

FILE: src/ehdc_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface ehdc_item_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TICK_WIDTH   = 48
);
  logic                             valid;
  logic                             ready;
  logic [ehdc_pkg::CMD_WIDTH-1:0]   cmd;
  logic [SAMPLE_WIDTH-1:0]          sample;
  logic [TICK_WIDTH-1:0]            tick;
  logic                             forced_level;

  modport source (output valid, cmd, sample, tick, forced_level, input ready);
  modport sink   (input valid, cmd, sample, tick, forced_level, output ready);
endinterface

interface ehdc_result_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic                    level;
  logic [SAMPLE_WIDTH-1:0] smoothed;

  modport source (output valid, level, smoothed, input ready);
  modport sink   (input valid, level, smoothed, output ready);
endinterface

interface ehdc_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [ehdc_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [ehdc_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/ehdc_core.sv
// Controller state and its combinational update: moving average, hysteresis and dwell check.
module ehdc_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TICK_WIDTH   = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  ehdc_pkg::ctrl_t                      ctrl,
  input  logic [SAMPLE_WIDTH-1:0]              sample,
  input  logic [TICK_WIDTH-1:0]                tick,
  input  logic [ehdc_pkg::ALPHA_WIDTH-1:0]     alpha,
  input  logic [SAMPLE_WIDTH-1:0]              high_mark,
  input  logic [SAMPLE_WIDTH-1:0]              low_mark,
  input  logic [TICK_WIDTH-1:0]                min_dwell,
  output logic                                 level,
  output logic [SAMPLE_WIDTH-1:0]              average
);

  localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH = ehdc_pkg::ALPHA_WIDTH + 1 + DIFF_WIDTH;

  logic                    seeded;
  logic [TICK_WIDTH-1:0]   last_change_tick;

  logic                    level_next;
  logic [SAMPLE_WIDTH-1:0] average_next;
  logic                    seeded_next;
  logic [TICK_WIDTH-1:0]   last_change_tick_next;

  logic signed [DIFF_WIDTH-1:0] diff;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] prod_scaled;
  logic signed [DIFF_WIDTH-1:0] ema_sum;
  logic [SAMPLE_WIDTH-1:0]      ema_value;
  logic [SAMPLE_WIDTH-1:0]      new_average;
  logic [TICK_WIDTH:0]          dwell_deadline;
  logic                         dwell_met;

  // Moving average as avg + floor(alpha * (sample - avg) / 2^16); same as the truncated blend
  assign diff        = $signed({1'b0, sample}) - $signed({1'b0, average});
  assign prod        = $signed({1'b0, alpha}) * diff;
  assign prod_scaled = prod >>> ehdc_pkg::ALPHA_FRAC;
  assign ema_sum     = $signed({1'b0, average}) + prod_scaled[DIFF_WIDTH-1:0];
  assign ema_value   = ema_sum[SAMPLE_WIDTH-1:0];

  // First sample after a clear seeds the average; raw sample when smoothing is off
  assign new_average = (ctrl.smoothing_on && seeded) ? ema_value : sample;

  // Dwell check with one guard bit so the deadline never wraps
  assign dwell_deadline = {1'b0, last_change_tick} + {1'b0, min_dwell};
  assign dwell_met      = ({1'b0, tick} >= dwell_deadline);

  // Work out the state after the item
  always_comb begin
    level_next            = level;
    average_next          = average;
    seeded_next           = seeded;
    last_change_tick_next = last_change_tick;
    case (ctrl.cmd)
      ehdc_pkg::CMD_UPDATE: begin
        average_next = new_average;
        seeded_next  = 1'b1;
        if (ctrl.hysteresis_on) begin
          if (!level) begin
            if ((new_average > high_mark) && dwell_met) begin
              level_next            = 1'b1;
              last_change_tick_next = tick;
            end
          end else begin
            if ((new_average < low_mark) && dwell_met) begin
              level_next            = 1'b0;
              last_change_tick_next = tick;
            end
          end
        end else begin
          level_next = (new_average >= high_mark);
        end
      end
      ehdc_pkg::CMD_FORCE: begin
        level_next            = ctrl.forced_level;
        last_change_tick_next = tick;
      end
      ehdc_pkg::CMD_CLEAR: begin
        level_next            = 1'b0;
        average_next          = '0;
        seeded_next           = 1'b0;
        last_change_tick_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Commit the state when the item moves into the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      level            <= 1'b0;
      average          <= '0;
      seeded           <= 1'b0;
      last_change_tick <= '0;
    end else if (advance) begin
      level            <= level_next;
      average          <= average_next;
      seeded           <= seeded_next;
      last_change_tick <= last_change_tick_next;
    end
  end

  // A clear leaves everything at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (advance && ctrl.cmd == ehdc_pkg::CMD_CLEAR) |=>
      (!level && average == '0 && !seeded && last_change_tick == '0))
    else $error("clear did not zero the controller state");

  // State moves only with an item
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(level) && $stable(average) && $stable(last_change_tick)))
    else $error("controller state changed without an item");

  // Raw sample passes straight through when smoothing is off
  a_raw_sample: assert property (@(posedge clk) disable iff (rst)
    (advance && ctrl.cmd == ehdc_pkg::CMD_UPDATE && !ctrl.smoothing_on) |=>
      (average == $past(sample) && seeded))
    else $error("raw sample not taken as average");

  // A forced level lands with its tick
  a_force: assert property (@(posedge clk) disable iff (rst)
    (advance && ctrl.cmd == ehdc_pkg::CMD_FORCE) |=>
      (level == $past(ctrl.forced_level) && last_change_tick == $past(tick)))
    else $error("force command not applied");

endmodule

FILE: src/ema_hysteresis_dwell_controller_top.sv
// Top level: configuration registers, input stage and result handshake around the core.
//
//  channel  direction  carries                                   transfer when
//  item     in         cmd, sample, tick, forced_level           item.valid & item.ready
//  result   out        level, smoothed                           result.valid & result.ready
//  cfg      in         index, data (alpha .. hysteresis_on)      cfg.valid & cfg.ready
//
// One item per cycle sustained while results are taken; an item's result is offered once it has
// passed the input register and then the state/result register, and transfers on result.ready.
// The combinational average multiply, watermark compare and dwell compare set the clock path.
// Reset (rst, synchronous) empties both stages, zeroes the state and loads register defaults.
// A stalled result holds; the input register still takes one more item behind it.
// Configuration writes are always ready.
module ema_hysteresis_dwell_controller_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TICK_WIDTH   = 48
) (
  input  logic          clk,
  input  logic          rst,
  ehdc_item_if.sink     item,
  ehdc_result_if.source result,
  ehdc_cfg_if.sink      cfg
);

  // Configuration registers
  logic [ehdc_pkg::ALPHA_WIDTH-1:0] alpha;
  logic [SAMPLE_WIDTH-1:0]          high_mark;
  logic [SAMPLE_WIDTH-1:0]          low_mark;
  logic [TICK_WIDTH-1:0]            min_dwell;
  logic                             smoothing_on;
  logic                             hysteresis_on;
  logic [ehdc_pkg::ALPHA_WIDTH-1:0] alpha_wr;

  // Input stage
  logic                           stage_valid;
  logic [ehdc_pkg::CMD_WIDTH-1:0] stage_cmd;
  logic [SAMPLE_WIDTH-1:0]        stage_sample;
  logic [TICK_WIDTH-1:0]          stage_tick;
  logic                           stage_forced;

  logic            result_valid;
  logic            advance;
  ehdc_pkg::ctrl_t ctrl;

  // Take configuration writes at any time; saturate alpha at one
  assign cfg.ready = 1'b1;
  assign alpha_wr  = cfg.data[ehdc_pkg::ALPHA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= ehdc_pkg::ALPHA_ONE;
      high_mark     <= '0;
      low_mark      <= '0;
      min_dwell     <= '0;
      smoothing_on  <= 1'b0;
      hysteresis_on <= 1'b0;
    end else if (cfg.valid) begin
      case (ehdc_pkg::reg_index_t'(cfg.index))
        ehdc_pkg::REG_ALPHA:
          alpha <= (alpha_wr > ehdc_pkg::ALPHA_ONE) ? ehdc_pkg::ALPHA_ONE : alpha_wr;
        ehdc_pkg::REG_HIGH_MARK:  high_mark     <= cfg.data[SAMPLE_WIDTH-1:0];
        ehdc_pkg::REG_LOW_MARK:   low_mark      <= cfg.data[SAMPLE_WIDTH-1:0];
        ehdc_pkg::REG_MIN_DWELL:  min_dwell     <= cfg.data[TICK_WIDTH-1:0];
        ehdc_pkg::REG_SMOOTHING:  smoothing_on  <= cfg.data[0];
        ehdc_pkg::REG_HYSTERESIS: hysteresis_on <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Advance an item into the result slot when that slot is free or being emptied
  assign advance    = stage_valid && (!result_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  // Input register: valid under reset, payload without reset and loaded on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_cmd    <= item.cmd;
      stage_sample <= item.sample;
      stage_tick   <= item.tick;
      stage_forced <= item.forced_level;
    end
  end

  // Result valid: set on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  assign ctrl.cmd           = ehdc_pkg::cmd_t'(stage_cmd);
  assign ctrl.forced_level  = stage_forced;
  assign ctrl.smoothing_on  = smoothing_on;
  assign ctrl.hysteresis_on = hysteresis_on;

  // State registers double as the result payload: they change only on advance
  ehdc_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TICK_WIDTH   (TICK_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctrl      (ctrl),
    .sample    (stage_sample),
    .tick      (stage_tick),
    .alpha     (alpha),
    .high_mark (high_mark),
    .low_mark  (low_mark),
    .min_dwell (min_dwell),
    .level     (result.level),
    .average   (result.smoothed)
  );

  assign result.valid = result_valid;

  // A result appears only from an item that advanced
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(advance))
    else $error("result raised without an item");

  // A full input stage facing a free result slot must move on
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !result_valid) |-> advance)
    else $error("input stage held while result slot empty");

  // Alpha never exceeds one
  a_alpha_sat: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (alpha <= ehdc_pkg::ALPHA_ONE))
    else $error("alpha above one");

endmodule
